@@ src/ddarc_pkg.sv @@
package ddarc_pkg;

	// datapath widths, sized for the full parameter ranges
	localparam int POS_W  = 22;
	localparam int DIR_W  = 16;
	localparam int CAM_W  = 22;
	localparam int RAY_W  = 24;
	localparam int ABS_W  = 23;
	localparam int NXT_W  = 24;
	localparam int MUL_W  = 25;
	localparam int PROD_W = 2 * MUL_W;
	localparam int NUM_W  = 40;
	localparam int DEN_W  = 24;
	localparam int CELL_W = 8;
	localparam int MADR_W = 12;
	localparam int CIDX_W = 3;
	localparam int CFG_W  = 22;

	localparam logic [NXT_W-1:0] ONE_CELL = NXT_W'(65536);

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_POS_X   = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_POS_Y   = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_DIR_X   = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_DIR_Y   = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_PLANE_X = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_PLANE_Y = 3'd5;

	localparam logic [POS_W-1:0]        RST_POS_X   = 22'd131072;
	localparam logic [POS_W-1:0]        RST_POS_Y   = 22'd131072;
	localparam logic signed [DIR_W-1:0] RST_DIR_X   = -16'sd16384;
	localparam logic signed [DIR_W-1:0] RST_DIR_Y   = 16'sd0;
	localparam logic signed [DIR_W-1:0] RST_PLANE_X = 16'sd0;
	localparam logic signed [DIR_W-1:0] RST_PLANE_Y = 16'sd10813;

	// wall types with a color of their own
	localparam logic [CELL_W-1:0] WALL_RED   = 8'd1;
	localparam logic [CELL_W-1:0] WALL_GREEN = 8'd2;
	localparam logic [CELL_W-1:0] WALL_GRAY  = 8'd5;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	function automatic rgb_t wall_color(input logic [CELL_W-1:0] wt, input logic ew);
		rgb_t c;
		c = '0;
		case (wt)
			WALL_RED:   c.r = 8'd255;
			WALL_GREEN: c.g = 8'd255;
			WALL_GRAY:  begin
				c.r = 8'd125;
				c.g = 8'd125;
				c.b = 8'd125;
			end
			default:    c.b = 8'd255;
		endcase
		if (ew) begin
			c.r = c.r >> 1;
			c.g = c.g >> 1;
			c.b = c.b >> 1;
		end
		return c;
	endfunction

endpackage

@@ src/ddarc_ram.sv @@
module ddarc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

@@ src/ddarc_div.sv @@
module ddarc_div #(
	parameter int NW = 40,
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);
	// restoring divider, one quotient bit per cycle
	logic [NW-1:0]           num_q;
	logic [DW-1:0]           den_q;
	logic [DW-1:0]           rem_q;
	logic [$clog2(NW+1)-1:0] cnt_q;
	logic                    run_q;
	logic                    done_q;
	logic [DW:0]             rem_sh;
	logic                    fits;

	assign rem_sh = {rem_q, num_q[NW-1]};
	assign fits   = rem_sh >= {1'b0, den_q};
	assign done   = done_q;
	assign quot   = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= ($clog2(NW+1))'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ($clog2(NW+1))'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
			num_q <= {num_q[NW-2:0], fits};
		end
	end
endmodule

@@ src/dda_raycast_column.sv @@
// Channel  | Direction | Handshake          | Payload
// request  | in        | in_valid/in_stall  | action, cell_x, cell_y, cell_value, column
// result   | out       | out_valid/out_stall| out_column .. wall_type
// config   | in        | cfg_wr_en          | cfg_index, cfg_wdata
//
// A cast runs through at most 2*MAP_SIZE+2 DDA steps: it first forms the ray (camera value by a
// constant reciprocal multiply, then plane*cam per axis on the shared multiplier), then per
// step does two cross products, the step and a map check, and last finds the height on the
// serial divider. A zero distance or zero ray component skips the divide; a start cell off
// the map skips the DDA steps and the divide. The final state holds while a full result
// register is stalled.
// After reset a clearing pass zeroes all 4096 map cells, one cell a cycle;
// requests stall during it, config writes are taken. A finished result sits
// in an output register, so the next request is taken while it waits.
module dda_raycast_column #(
	parameter int MAP_SIZE      = 64,
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [ddarc_pkg::CIDX_W-1:0] cfg_index,
	input  logic [ddarc_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       action,
	input  logic [5:0]                 cell_x,
	input  logic [5:0]                 cell_y,
	input  logic [7:0]                 cell_value,
	input  logic [8:0]                 column,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [8:0]                 out_column,
	output logic [7:0]                 draw_start,
	output logic [7:0]                 draw_end,
	output logic [7:0]                 red,
	output logic [7:0]                 green,
	output logic [7:0]                 blue,
	output logic                       side_ew,
	output logic [7:0]                 wall_type
);
	import ddarc_pkg::*;

	localparam int LIM   = 2 * MAP_SIZE + 2;
	localparam int LIM_W = $clog2(LIM + 1);
	localparam int HALF  = SCREEN_HEIGHT / 2;
	localparam logic signed [7:0] MAP_S = 8'(MAP_SIZE);

	// floor(col * 2^15 / W) as (col * ceil(2^35 / W)) >> 20, exact for 9-bit columns
	localparam int          CAM_SH = 20;
	localparam logic [31:0] CAM_M  =
		32'(((64'd1 << 35) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CAMGO = 4'd1;
	localparam logic [3:0] S_MULX  = 4'd3;
	localparam logic [3:0] S_MULY  = 4'd4;
	localparam logic [3:0] S_INIT  = 4'd5;
	localparam logic [3:0] S_OOB   = 4'd6;
	localparam logic [3:0] S_P1    = 4'd7;
	localparam logic [3:0] S_P2    = 4'd8;
	localparam logic [3:0] S_STEP  = 4'd9;
	localparam logic [3:0] S_CHK   = 4'd10;
	localparam logic [3:0] S_HGT   = 4'd11;
	localparam logic [3:0] S_HDIV  = 4'd12;
	localparam logic [3:0] S_HWAIT = 4'd13;
	localparam logic [3:0] S_FIN   = 4'd14;

	function automatic logic [5:0] clamp_cell(input logic signed [7:0] v);
		logic [5:0] c;
		if (v < 0)
			c = '0;
		else if (v > MAP_S - 8'sd1)
			c = 6'(MAP_SIZE - 1);
		else
			c = v[5:0];
		return c;
	endfunction

	// camera registers
	logic [POS_W-1:0]        pos_x_q, pos_y_q;
	logic signed [DIR_W-1:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= RST_POS_X;
			pos_y_q   <= RST_POS_Y;
			dir_x_q   <= RST_DIR_X;
			dir_y_q   <= RST_DIR_Y;
			plane_x_q <= RST_PLANE_X;
			plane_y_q <= RST_PLANE_Y;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_POS_X:   pos_x_q   <= cfg_wdata;
				CFG_POS_Y:   pos_y_q   <= cfg_wdata;
				CFG_DIR_X:   dir_x_q   <= cfg_wdata[DIR_W-1:0];
				CFG_DIR_Y:   dir_y_q   <= cfg_wdata[DIR_W-1:0];
				CFG_PLANE_X: plane_x_q <= cfg_wdata[DIR_W-1:0];
				CFG_PLANE_Y: plane_y_q <= cfg_wdata[DIR_W-1:0];
				default:     ;
			endcase
		end
	end

	// control
	logic [3:0]        state_q;
	logic              clr_q;
	logic [MADR_W-1:0] clr_addr_q;
	logic [LIM_W-1:0]  i_q;
	logic              out_valid_q;

	// datapath
	logic [8:0]               col_q;
	logic signed [CAM_W-1:0]  cam_q;
	logic signed [RAY_W-1:0]  rx_q, ry_q;
	logic signed [7:0]        mx_q, my_q;
	logic [NXT_W-1:0]         nx_q, ny_q, dnum_q;
	logic [ABS_W-1:0]         r_q;
	logic                     side_q;
	logic [CELL_W-1:0]        wt_q;
	logic signed [PROD_W-1:0] prod_q, p1_q;
	logic [NUM_W-1:0]         h_q;

	// result register
	logic [8:0]  oc_q;
	logic [7:0]  ds_q, de_q, wto_q;
	rgb_t        rgb_q;
	logic        ew_q;

	logic accept, load, take_x, stop;
	logic [ABS_W-1:0] ax, ay;
	logic signed [RAY_W-1:0] ray_new, ry_new;
	logic [40:0] cam_prod;
	logic signed [7:0] sx, sy, mx_nxt, my_nxt, rd_x, rd_y;
	logic [5:0] mx0, my0;
	logic oob0;
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic div_start, div_done;
	logic [NUM_W-1:0] div_num, div_quot;
	logic [DEN_W-1:0] div_den;
	logic ram_we;
	logic [MADR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata, ram_rdata;
	logic [LIM_W-1:0] i_nxt;
	logic [NUM_W-1:0] h2, de_w;
	logic [NUM_W-1:0] ds_w;

	assign in_stall  = clr_q || (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign load      = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	assign ax = rx_q[RAY_W-1] ? ABS_W'(-rx_q) : ABS_W'(rx_q);
	assign ay = ry_q[RAY_W-1] ? ABS_W'(-ry_q) : ABS_W'(ry_q);
	assign sx = rx_q[RAY_W-1] ? -8'sd1 : 8'sd1;
	assign sy = ry_q[RAY_W-1] ? -8'sd1 : 8'sd1;

	assign cam_prod = 41'(col_q) * 41'(CAM_M);

	// floor of plane * cam / 2^14, added to the direction
	assign ray_new = $signed(prod_q[RAY_W+13:14]);
	assign ry_new  = RAY_W'(dir_y_q) + ray_new;

	// step along x when x's boundary is strictly nearer; ties go to y
	assign take_x = (ax != '0) && ((ay == '0) || (p1_q < prod_q));
	assign mx_nxt = take_x ? mx_q + sx : mx_q;
	assign my_nxt = take_x ? my_q : my_q + sy;

	assign mx0  = pos_x_q[POS_W-1:16];
	assign my0  = pos_y_q[POS_W-1:16];
	assign oob0 = ({2'b0, mx0} >= MAP_S) || ({2'b0, my0} >= MAP_S);

	assign i_nxt = i_q + 1'b1;
	assign stop  = (mx_q < 0) || (my_q < 0) || (mx_q >= MAP_S) || (my_q >= MAP_S)
		|| (ram_rdata != '0) || (i_nxt == LIM_W'(LIM));

	// map read address
	always_comb begin
		rd_x = mx_q;
		rd_y = my_q;
		if (state_q == S_INIT) begin
			rd_x = {2'b0, mx0};
			rd_y = {2'b0, my0};
		end else if (state_q == S_STEP) begin
			rd_x = mx_nxt;
			rd_y = my_nxt;
		end
	end

	// map write port: clearing pass or a write request
	always_comb begin
		if (clr_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = accept && !action && ({1'b0, cell_x} < 7'(MAP_SIZE))
				&& ({1'b0, cell_y} < 7'(MAP_SIZE));
			ram_waddr = {cell_x, cell_y};
			ram_wdata = cell_value;
		end
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MULX: begin
				mul_a = MUL_W'(plane_x_q);
				mul_b = MUL_W'(cam_q);
			end
			S_MULY: begin
				mul_a = MUL_W'(plane_y_q);
				mul_b = MUL_W'(cam_q);
			end
			S_P1: begin
				mul_a = MUL_W'(nx_q);
				mul_b = MUL_W'(ay);
			end
			S_P2: begin
				mul_a = MUL_W'(ny_q);
				mul_b = MUL_W'(ax);
			end
			S_HGT: begin
				mul_a = MUL_W'(4 * SCREEN_HEIGHT);
				mul_b = MUL_W'(r_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// divider: wall height only
	assign div_start = (state_q == S_HDIV);
	assign div_num   = prod_q[NUM_W-1:0];
	assign div_den   = dnum_q;

	ddarc_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	ddarc_ram #(.WIDTH(CELL_W), .DEPTH(4096)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr ({clamp_cell(rd_x), clamp_cell(rd_y)}),
		.rdata (ram_rdata)
	);

	// slice rows from the height
	assign h2   = h_q >> 1;
	assign ds_w = (h2 < NUM_W'(HALF)) ? NUM_W'(HALF) - h2 : '0;
	assign de_w = (h2 + NUM_W'(HALF) > NUM_W'(SCREEN_HEIGHT - 1))
		? NUM_W'(SCREEN_HEIGHT - 1) : h2 + NUM_W'(HALF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clr_q       <= 1'b1;
			clr_addr_q  <= '0;
			i_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == '1)
					clr_q <= 1'b0;
			end
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE:  if (accept && action) state_q <= S_CAMGO;
				S_CAMGO: state_q <= S_MULX;
				S_MULX:  state_q <= S_MULY;
				S_MULY:  state_q <= S_INIT;
				S_INIT:  begin
					i_q     <= '0;
					state_q <= oob0 ? S_OOB : S_P1;
				end
				S_OOB:   state_q <= S_HGT;
				S_P1:    state_q <= S_P2;
				S_P2:    state_q <= S_STEP;
				S_STEP:  state_q <= S_CHK;
				S_CHK:   begin
					i_q     <= i_nxt;
					state_q <= stop ? S_HGT : S_P1;
				end
				S_HGT:   state_q <= (dnum_q == '0 || r_q == '0) ? S_FIN : S_HDIV;
				S_HDIV:  state_q <= S_HWAIT;
				S_HWAIT: if (div_done) state_q <= S_FIN;
				S_FIN:   if (load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE:  col_q <= column;
			S_CAMGO: cam_q <= CAM_W'(cam_prod[40:CAM_SH]) - CAM_W'(16384);
			S_MULY:  rx_q  <= RAY_W'(dir_x_q) + ray_new;
			S_INIT:  begin
				ry_q   <= ry_new;
				mx_q   <= {2'b0, mx0};
				my_q   <= {2'b0, my0};
				nx_q   <= rx_q[RAY_W-1] ? NXT_W'(pos_x_q[15:0])
					: ONE_CELL - NXT_W'(pos_x_q[15:0]);
				ny_q   <= ry_new[RAY_W-1] ? NXT_W'(pos_y_q[15:0])
					: ONE_CELL - NXT_W'(pos_y_q[15:0]);
				dnum_q <= '0;
				r_q    <= '0;
				side_q <= 1'b0;
			end
			S_OOB:   wt_q <= ram_rdata;
			S_P1:    ;
			S_P2:    p1_q <= prod_q;
			S_STEP:  begin
				mx_q <= mx_nxt;
				my_q <= my_nxt;
				if (take_x) begin
					dnum_q <= nx_q;
					r_q    <= ax;
					nx_q   <= nx_q + ONE_CELL;
					side_q <= 1'b0;
				end else begin
					dnum_q <= ny_q;
					r_q    <= ay;
					ny_q   <= ny_q + ONE_CELL;
					side_q <= 1'b1;
				end
			end
			S_CHK:   wt_q <= ram_rdata;
			S_HGT:   h_q  <= (dnum_q == '0) ? NUM_W'(SCREEN_HEIGHT) : '0;
			S_HWAIT: if (div_done) h_q <= div_quot;
			default: ;
		endcase
		if (load) begin
			oc_q  <= col_q;
			ds_q  <= ds_w[7:0];
			de_q  <= de_w[7:0];
			rgb_q <= wall_color(wt_q, side_q);
			ew_q  <= side_q;
			wto_q <= wt_q;
		end
	end

	assign out_column = oc_q;
	assign draw_start = ds_q;
	assign draw_end   = de_q;
	assign red        = rgb_q.r;
	assign green      = rgb_q.g;
	assign blue       = rgb_q.b;
	assign side_ew    = ew_q;
	assign wall_type  = wto_q;
endmodule

@@ src/ddarc_checker.sv @@
module ddarc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       action,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic       side_ew,
	input logic [7:0] wall_type
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_cast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action |=> in_stall)
		else $error("cast request did not make the block busy");

	a_shade: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && side_ew |-> !red[7] && !green[7] && !blue[7])
		else $error("east-west face not shaded");

	a_red: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !side_ew && wall_type == 8'd1 |-> red == 8'd255)
		else $error("wrong color for red wall");
endmodule

bind dda_raycast_column ddarc_checker u_ddarc_checker (.*);

@@ tb/sv/dda_raycast_column_checker.sv @@
`timescale 1ns / 100ps

module dda_raycast_column_checker #(
	parameter int MAP_SIZE      = 64,
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [ddarc_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [ddarc_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           action,
	input  logic [5:0]                     cell_x,
	input  logic [5:0]                     cell_y,
	input  logic [7:0]                     cell_value,
	input  logic [8:0]                     column,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [8:0]                     out_column,
	input  logic [7:0]                     draw_start,
	input  logic [7:0]                     draw_end,
	input  logic [7:0]                     red,
	input  logic [7:0]                     green,
	input  logic [7:0]                     blue,
	input  logic                           side_ew,
	input  logic [7:0]                     wall_type,
	output int                             fail_count,
	output int                             pending
);
	import ddarc_pkg::*;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_CAST  = 1'b1;

	typedef struct {
		logic [8:0] col;
		logic [7:0] ds;
		logic [7:0] de;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       ew;
		logic [7:0] wt;
	} slice_t;

	logic [7:0]        grid [4096];
	logic [POS_W-1:0]  cam_px, cam_py;
	logic signed [15:0] cam_dx, cam_dy, cam_plx, cam_ply;
	slice_t            slices_due [$];

	function automatic logic [7:0] grid_at(longint x, longint y);
		if (x < 0) x = 0;
		if (y < 0) y = 0;
		if (x > MAP_SIZE - 1) x = MAP_SIZE - 1;
		if (y > MAP_SIZE - 1) y = MAP_SIZE - 1;
		return grid[x * 64 + y];
	endfunction

	function automatic slice_t trace_column(logic [8:0] col);
		longint cam, rx, ry, ax, ay, px, py, mx, my, sx, sy, nx, ny;
		longint dnum, rr, height, ds, de;
		logic ew;
		logic [7:0] wt;
		bit take_x;
		slice_t s;
		cam = longint'(col) * 32768 / SCREEN_WIDTH - 16384;
		// arithmetic shift floors toward minus infinity
		rx = longint'(cam_dx) + ((longint'(cam_plx) * cam) >>> 14);
		ry = longint'(cam_dy) + ((longint'(cam_ply) * cam) >>> 14);
		ax = rx < 0 ? -rx : rx;
		ay = ry < 0 ? -ry : ry;
		px = longint'(cam_px);
		py = longint'(cam_py);
		mx = px >>> 16;
		my = py >>> 16;
		dnum = 0;
		rr = 0;
		ew = 0;
		if (mx >= MAP_SIZE || my >= MAP_SIZE) begin
			wt = grid_at(mx, my);
		end else begin
			sx = rx < 0 ? -1 : 1;
			sy = ry < 0 ? -1 : 1;
			nx = rx < 0 ? px - (mx << 16) : ((mx + 1) << 16) - px;
			ny = ry < 0 ? py - (my << 16) : ((my + 1) << 16) - py;
			wt = 0;
			for (int i = 0; i < 2 * MAP_SIZE + 2; i++) begin
				take_x = ax != 0 && (ay == 0 || nx * ay < ny * ax);
				if (take_x) begin
					dnum = nx; rr = ax; nx += 65536; mx += sx; ew = 0;
				end else begin
					dnum = ny; rr = ay; ny += 65536; my += sy; ew = 1;
				end
				wt = grid_at(mx, my);
				if (mx < 0 || my < 0 || mx >= MAP_SIZE || my >= MAP_SIZE) break;
				if (wt != 0) break;
			end
		end
		if (dnum == 0) height = SCREEN_HEIGHT;
		else if (rr == 0) height = 0;
		else height = (4 * SCREEN_HEIGHT * rr) / dnum;
		ds = SCREEN_HEIGHT / 2 - height / 2;
		if (ds < 0) ds = 0;
		de = height / 2 + SCREEN_HEIGHT / 2;
		if (de > SCREEN_HEIGHT - 1) de = SCREEN_HEIGHT - 1;
		s.r = 0; s.g = 0; s.b = 0;
		case (wt)
			WALL_RED:   s.r = 8'd255;
			WALL_GREEN: s.g = 8'd255;
			WALL_GRAY:  begin
				s.r = 8'd125; s.g = 8'd125; s.b = 8'd125;
			end
			default:    s.b = 8'd255;
		endcase
		if (ew) begin
			s.r >>= 1; s.g >>= 1; s.b >>= 1;
		end
		s.col = col;
		s.ds = 8'(ds);
		s.de = 8'(de);
		s.ew = ew;
		s.wt = wt;
		return s;
	endfunction

	task automatic cmp8(string name, logic [8:0] want, logic [8:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		slice_t s;
		if (!arst_n) begin
			foreach (grid[i]) grid[i] = '0;
			cam_px  = RST_POS_X;
			cam_py  = RST_POS_Y;
			cam_dx  = RST_DIR_X;
			cam_dy  = RST_DIR_Y;
			cam_plx = RST_PLANE_X;
			cam_ply = RST_PLANE_Y;
			slices_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_POS_X:   cam_px  = cfg_wdata[POS_W-1:0];
					CFG_POS_Y:   cam_py  = cfg_wdata[POS_W-1:0];
					CFG_DIR_X:   cam_dx  = cfg_wdata[15:0];
					CFG_DIR_Y:   cam_dy  = cfg_wdata[15:0];
					CFG_PLANE_X: cam_plx = cfg_wdata[15:0];
					CFG_PLANE_Y: cam_ply = cfg_wdata[15:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (slices_due.size() == 0) begin
					$error("result for column %0d with no request waiting", out_column);
					fail_count++;
				end else begin
					s = slices_due.pop_front();
					cmp8("out_column", s.col, out_column);
					cmp8("draw_start", s.ds, draw_start);
					cmp8("draw_end", s.de, draw_end);
					cmp8("red", s.r, red);
					cmp8("green", s.g, green);
					cmp8("blue", s.b, blue);
					cmp8("side_ew", s.ew, side_ew);
					cmp8("wall_type", s.wt, wall_type);
				end
			end
			if (in_valid && !in_stall) begin
				if (action == ACT_WRITE) grid[{cell_x, cell_y}] = cell_value;
				else slices_due.push_back(trace_column(column));
			end
			pending = slices_due.size();
		end
	end

endmodule

@@ tb/sv/dda_raycast_column_tb.sv @@
`timescale 1ns / 100ps

module dda_raycast_column_tb;
	import ddarc_pkg::*;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_CAST  = 1'b1;

	logic              clk, arst_n;
	logic              cfg_wr_en;
	logic [CIDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]  cfg_wdata;
	logic              in_valid, in_stall;
	logic              action;
	logic [5:0]        cell_x, cell_y;
	logic [7:0]        cell_value;
	logic [8:0]        column;
	logic              out_valid, out_stall;
	logic [8:0]        out_column;
	logic [7:0]        draw_start, draw_end, red, green, blue, wall_type;
	logic              side_ew;
	int                fail_count, pending;

	// quiet: no idling on either side; hold_req: one long receiver hold-off
	bit quiet, hold_req, hold_done;

	dda_raycast_column u_top (.*);

	dda_raycast_column_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Hard stop.
	initial begin
		#8ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// Result side: random stall bursts, plus one long hold so the block backs up
	initial begin
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1;
				repeat (3000) @(posedge clk);
				out_stall <= 0;
				hold_done = 1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_stall <= 1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				out_stall <= 0;
			end
		end
	end

	// Offer one request and hold it until taken; optionally idle afterwards.
	task automatic send_req(logic act, logic [5:0] cx, logic [5:0] cy,
			logic [7:0] cv, logic [8:0] col);
		action     <= act;
		cell_x     <= cx;
		cell_y     <= cy;
		cell_value <= cv;
		column     <= col;
		in_valid   <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic cast(logic [8:0] col);
		send_req(ACT_CAST, 6'($urandom), 6'($urandom), 8'($urandom), col);
	endtask

	task automatic put_cell(logic [5:0] cx, logic [5:0] cy, logic [7:0] cv);
		send_req(ACT_WRITE, cx, cy, cv, 9'($urandom));
	endtask

	// Drain everything, then load a full camera setting.
	task automatic load_camera(logic [21:0] px, logic [21:0] py, logic [15:0] dx,
			logic [15:0] dy, logic [15:0] plx, logic [15:0] ply);
		logic [21:0] vals [6];
		vals = '{px, py, 22'(dx), 22'(dy), 22'(plx), 22'(ply)};
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);  // writes have no result; let the last one land
		for (int i = 0; i < 6; i++) begin
			cfg_wr_en <= 1;
			cfg_index <= CIDX_W'(i);
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		cfg_wr_en <= 0;
	endtask

	function automatic logic [7:0] wall_pick();
		case ($urandom_range(0, 5))
			0: return WALL_RED;
			1: return WALL_GREEN;
			2: return WALL_GRAY;
			3: return 8'd0;
			default: return 8'($urandom);
		endcase
	endfunction

	initial begin
		arst_n     = 0;
		cfg_wr_en  = 0;
		cfg_index  = '0;
		cfg_wdata  = '0;
		in_valid   = 0;
		action     = 0;
		cell_x     = 0;
		cell_y     = 0;
		cell_value = 0;
		column     = 0;
		quiet      = 0;
		hold_req   = 0;
		hold_done  = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: reset camera over an empty map, so the ray runs off the edge
		cast(9'd0);
		cast(9'd160);
		cast(9'd319);
		cast(9'd320);
		cast(9'd511);
		put_cell(6'd0, 6'd0, 8'd255);
		put_cell(6'd63, 6'd63, WALL_RED);
		put_cell(6'd0, 6'd2, WALL_GREEN);
		put_cell(6'd1, 6'd2, WALL_GRAY);
		put_cell(6'd2, 6'd2, 8'd7);      // start cell is never tested
		put_cell(6'd2, 6'd3, WALL_GRAY);
		cast(9'd0);
		cast(9'd160);
		cast(9'd319);
		cast(9'd511);

		// Register extremes, including both ray components at zero
		load_camera(22'd0, 22'h3FFFFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
		cast(9'd0); cast(9'd319); cast(9'd511);
		load_camera(22'h3FFFFF, 22'd0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
		cast(9'd0); cast(9'd160); cast(9'd511);
		load_camera(22'h020000, 22'h020000, 16'd0, 16'd0, 16'd0, 16'd0);
		cast(9'd0); cast(9'd300);
		// exact boundary position
		load_camera(22'h100000, 22'h100000, 16'h4000, 16'h0000, 16'h0000, 16'h2A3D);
		cast(9'd160); cast(9'd40);

		// Random phases: walls dense enough that most rays hit something
		for (int ph = 0; ph < 12; ph++) begin
			if (ph >= 10) quiet = 1;
			load_camera(22'($urandom_range(0, 22'h3FFFFF)), 22'($urandom_range(0, 22'h3FFFFF)),
				16'($urandom), 16'($urandom),
				16'($signed($urandom_range(0, 24000)) - 12000),
				16'($signed($urandom_range(0, 24000)) - 12000));
			// long hold starts once requests flow again, so the block backs up
			if (ph == 3) hold_req = 1;
			for (int k = 0; k < 75; k++) begin
				if ($urandom_range(0, 9) < 4) put_cell(6'($urandom), 6'($urandom), wall_pick());
				else if ($urandom_range(0, 7) == 0) cast(9'($urandom_range(320, 511)));
				else cast(9'($urandom_range(0, 319)));
			end
		end

		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
		if (fail_count == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ dda_raycast_column.f @@
src/ddarc_pkg.sv
src/ddarc_ram.sv
src/ddarc_div.sv
src/dda_raycast_column.sv
src/ddarc_checker.sv
tb/sv/dda_raycast_column_checker.sv
tb/sv/dda_raycast_column_tb.sv
